@@ rtl/sliding_window_median_alert_top_assert.svh @@
// Assertion macros for the sliding window median alert block.
// Used by the port checker; needs clk and rst_n in the scope of each use.
`ifndef SLIDING_WINDOW_MEDIAN_ALERT_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ALERT_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define SWMA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swma: port check failed");

// Checked at every edge, reset included.
`define SWMA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swma: port check failed during or after reset");

`endif

@@ rtl/swma_pkg.sv @@
// Shared types and constants for the sliding window median alert block.
// No dependencies; imported by the histogram, ring and top-level RTL modules.
package swma_pkg;

  // Default sizes of the histogram and of the sample ring.
  localparam int unsigned NUM_BINS_DEF   = 256;
  localparam int unsigned MAX_WINDOW_DEF = 1024;

  // Fixed field and register widths.
  localparam int unsigned AMT_W     = 8;
  localparam int unsigned WIN_REG_W = 11;
  localparam int unsigned TM_W      = 9;
  localparam int unsigned ALERT_W   = 32;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  // Register map and reset values.
  localparam logic [PADDR_W-1:0]   ADDR_WINDOW_DAYS = '0;
  localparam logic [WIN_REG_W-1:0] WIN_RESET        = 11'd5;

  // Operations issued to the histogram memory.
  typedef enum logic [2:0] {
    HOP_NOP,
    HOP_CLEAR,
    HOP_SCAN,
    HOP_READ,
    HOP_DEC,
    HOP_INC
  } hist_op_t;

  // Commands to the sample ring.
  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } ring_cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DEC,
    ST_DEC_WR,
    ST_INC,
    ST_INC_WR,
    ST_DONE
  } ctrl_state_t;

endpackage

@@ rtl/swma_hist.sv @@
// Histogram memory of bin counts with its clear, scan and update logic.
// Depends on swma_pkg; driven by the sequencer in the top level.
module swma_hist import swma_pkg::*; #(
  parameter int unsigned NUM_BINS   = NUM_BINS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hist_op_t                           op,
  input  logic [$clog2(NUM_BINS)-1:0]        addr,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    low_rank,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    high_rank,
  output logic [$clog2(NUM_BINS)-1:0]        low_bin,
  output logic [$clog2(NUM_BINS)-1:0]        high_bin
);

  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  logic [CNT_W-1:0] bin_mem [NUM_BINS];
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_en;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic             scan_vld_r;
  logic [BIN_W-1:0] scan_idx_r;
  logic [BIN_W-1:0] rmw_addr_r;
  logic [CNT_W:0]   cum_r;
  logic [CNT_W:0]   cum_nxt;
  logic             low_found_r;
  logic             low_found_nxt;
  logic             high_found_r;
  logic             high_found_nxt;
  logic [BIN_W-1:0] low_bin_r;
  logic [BIN_W-1:0] low_bin_nxt;
  logic [BIN_W-1:0] high_bin_r;
  logic [BIN_W-1:0] high_bin_nxt;

  // Port selection: scans and read-modify-write reads share the read port.
  always_comb begin
    rd_en   = (op == HOP_SCAN) || (op == HOP_READ);
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    unique case (op)
      HOP_CLEAR: begin
        wr_en = 1'b1;
      end
      HOP_DEC: begin
        wr_en   = (rd_data_r != '0);
        wr_addr = rmw_addr_r;
        wr_data = rd_data_r - CNT_W'(1);
      end
      HOP_INC: begin
        wr_en   = 1'b1;
        wr_addr = rmw_addr_r;
        wr_data = rd_data_r + CNT_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Single-port memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bin_mem[addr];
    end
  end

  // Running sum over the bins; the first bin of a scan restarts the search.
  always_comb begin
    logic first;
    first          = (scan_idx_r == '0);
    cum_nxt        = (first ? '0 : cum_r) + {1'b0, rd_data_r};
    low_found_nxt  = first ? 1'b0 : low_found_r;
    high_found_nxt = first ? 1'b0 : high_found_r;
    low_bin_nxt    = first ? LAST_BIN : low_bin_r;
    high_bin_nxt   = first ? LAST_BIN : high_bin_r;
    if (!low_found_nxt && (cum_nxt > {1'b0, low_rank})) begin
      low_bin_nxt   = scan_idx_r;
      low_found_nxt = 1'b1;
    end
    if (!high_found_nxt && (cum_nxt > {1'b0, high_rank})) begin
      high_bin_nxt   = scan_idx_r;
      high_found_nxt = 1'b1;
    end
  end

  // Marks the cycle in which scan data arrives from the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= (op == HOP_SCAN);
    end
  end

  // Scan bookkeeping and the address of the pending update.
  always_ff @(posedge clk) begin
    if (op == HOP_SCAN) begin
      scan_idx_r <= addr;
    end
    if (op == HOP_READ) begin
      rmw_addr_r <= addr;
    end
    if (scan_vld_r) begin
      cum_r        <= cum_nxt;
      low_found_r  <= low_found_nxt;
      high_found_r <= high_found_nxt;
      low_bin_r    <= low_bin_nxt;
      high_bin_r   <= high_bin_nxt;
    end
  end

  assign low_bin  = low_bin_r;
  assign high_bin = high_bin_r;

endmodule

@@ rtl/swma_ring.sv @@
// Ring memory of window samples with its slot pointer and fill level.
// Depends on swma_pkg; driven by the sequencer in the top level.
module swma_ring import swma_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] win,
  input  ring_cmd_t                       cmd,
  input  logic [AMT_W-1:0]                wr_data,
  output logic [AMT_W-1:0]                rd_data,
  output logic                            full
);

  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [AMT_W-1:0]   ring_mem [MAX_WINDOW];
  logic [AMT_W-1:0]   rd_data_r;
  logic [RING_AW-1:0] ptr_r;
  logic [RING_AW-1:0] ptr_nxt;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   ptr_inc;

  assign full = (fill_r >= win);

  // The slot after the current one, wrapping at the window length.
  always_comb begin
    ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);
    ptr_nxt = (ptr_inc >= win) ? '0 : RING_AW'(ptr_inc);
  end

  // Pointer and fill level; a window restart clears both.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.clear) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.wr) begin
      ptr_r <= ptr_nxt;
      if (!full) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  // Sample storage: the oldest sample is read, then overwritten in place.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ring_mem[ptr_r] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= ring_mem[ptr_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sliding_window_median_alert_top.sv @@
// Sliding window median alert: one sample in, one result out per transfer.
// An item taken while the window fills only increments its bin. Once the window is full,
// the histogram memory is read one bin per cycle through its single read port to find twice the
// median, then the oldest bin is decremented and the new bin incremented by read-modify-write.
// After reset and after every write of window_days, a clearing pass zeroes the histogram,
// during which in_ready stays low. A finished result waits in an output register, so the next
// sample is taken while it is still held. window_days sits at byte address 0; 0 is treated as a
// window of 1 and values above MAX_WINDOW as MAX_WINDOW. The alert count saturates and survives
// window changes.
module sliding_window_median_alert_top import swma_pkg::*; #(
  parameter int unsigned NUM_BINS   = NUM_BINS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [AMT_W-1:0]   in_amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_window_full,
  output logic [TM_W-1:0]    out_twice_median,
  output logic               out_notify,
  output logic [ALERT_W-1:0] out_alert_count
);

  localparam int unsigned BIN_W  = $clog2(NUM_BINS);
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = BIN_W + 1;
  localparam int unsigned WCMP_W = (WIN_REG_W > CNT_W) ? WIN_REG_W : CNT_W;
  localparam int unsigned SAT_W  = (AMT_W > BIN_W) ? AMT_W : BIN_W;
  localparam int unsigned GE_W   = (AMT_W > SUM_W) ? AMT_W : SUM_W;
  localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(NUM_BINS - 1);
  localparam logic [SAT_W-1:0]   BIN_MAX   = SAT_W'(NUM_BINS - 1);
  localparam logic [ALERT_W-1:0] ALERT_MAX = '1;

  ctrl_state_t        state_r;
  ctrl_state_t        state_nxt;
  logic [BIN_W-1:0]   clr_idx_r;
  logic [BIN_W-1:0]   clr_idx_nxt;
  logic [BIN_W-1:0]   scan_idx_r;
  logic [BIN_W-1:0]   scan_idx_nxt;
  logic [WIN_REG_W-1:0] win_reg_r;
  logic [ALERT_W-1:0] alerts_r;
  logic [ALERT_W-1:0] alerts_nxt;

  logic [AMT_W-1:0]   amt_r;
  logic [AMT_W-1:0]   amt_nxt;
  logic               full_r;
  logic               full_nxt;
  logic [SUM_W-1:0]   twice_r;
  logic [SUM_W-1:0]   twice_nxt;
  logic               notify_r;
  logic               notify_nxt;

  logic               out_valid_r;
  logic               out_full_r;
  logic [TM_W-1:0]    out_twice_r;
  logic               out_notify_r;
  logic [ALERT_W-1:0] out_alerts_r;
  logic               out_load;

  logic               cfg_wr;
  logic [CNT_W-1:0]   win_eff;
  logic [CNT_W-1:0]   low_rank;
  logic [CNT_W-1:0]   high_rank;
  logic [SAT_W-1:0]   amt_sat;
  logic [SUM_W-1:0]   twice_sum;
  logic               amt_ge;

  hist_op_t           hist_op;
  logic [BIN_W-1:0]   hist_addr;
  logic [BIN_W-1:0]   low_bin;
  logic [BIN_W-1:0]   high_bin;
  ring_cmd_t          ring_cmd;
  logic [AMT_W-1:0]   ring_old;
  logic               ring_full;

  // Configuration port: one register, written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_DAYS);
  assign prdata = (paddr == ADDR_WINDOW_DAYS) ? PDATA_W'(win_reg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_reg_r <= WIN_RESET;
    end else if (cfg_wr) begin
      win_reg_r <= pwdata[WIN_REG_W-1:0];
    end
  end

  // Effective window length and the two middle ranks.
  always_comb begin
    logic [WCMP_W-1:0] win_ext;
    win_ext = WCMP_W'(win_reg_r);
    if (win_ext == '0) begin
      win_eff = CNT_W'(1);
    end else if (win_ext > WCMP_W'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(win_ext);
    end
    low_rank  = (win_eff - CNT_W'(1)) >> 1;
    high_rank = win_eff >> 1;
  end

  // Sample clamped to the last bin; twice the median and the alert test.
  always_comb begin
    logic [SAT_W-1:0] amt_ext;
    amt_ext   = SAT_W'(in_amount);
    amt_sat   = (amt_ext > BIN_MAX) ? BIN_MAX : amt_ext;
    twice_sum = SUM_W'(low_bin) + SUM_W'(high_bin);
    amt_ge    = (GE_W'(amt_r) >= GE_W'(twice_sum));
  end

  // Sequencer: next state, memory commands and item bookkeeping.
  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    scan_idx_nxt = scan_idx_r;
    amt_nxt      = amt_r;
    full_nxt     = full_r;
    twice_nxt    = twice_r;
    notify_nxt   = notify_r;
    alerts_nxt   = alerts_r;
    hist_op      = HOP_NOP;
    hist_addr    = '0;
    ring_cmd     = '0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        hist_op     = HOP_CLEAR;
        hist_addr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + BIN_W'(1);
        if (clr_idx_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !cfg_wr;
        if (in_valid && !cfg_wr) begin
          amt_nxt     = AMT_W'(amt_sat);
          full_nxt    = ring_full;
          twice_nxt   = '0;
          notify_nxt  = 1'b0;
          ring_cmd.rd = 1'b1;
          if (ring_full) begin
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_INC;
          end
        end
      end
      ST_SCAN: begin
        hist_op      = HOP_SCAN;
        hist_addr    = scan_idx_r;
        scan_idx_nxt = scan_idx_r + BIN_W'(1);
        if (scan_idx_r == LAST_BIN) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // The last bin's count is still being summed in this cycle.
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        twice_nxt  = twice_sum;
        notify_nxt = amt_ge;
        if (amt_ge && (alerts_r != ALERT_MAX)) begin
          alerts_nxt = alerts_r + ALERT_W'(1);
        end
        hist_op   = HOP_READ;
        hist_addr = BIN_W'(ring_old);
        state_nxt = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        hist_op   = HOP_DEC;
        state_nxt = ST_INC;
      end
      ST_INC: begin
        hist_op   = HOP_READ;
        hist_addr = BIN_W'(amt_r);
        state_nxt = ST_INC_WR;
      end
      ST_INC_WR: begin
        hist_op     = HOP_INC;
        ring_cmd.wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    // A window write restarts the window and sweeps the histogram.
    if (cfg_wr) begin
      state_nxt      = ST_CLEAR;
      clr_idx_nxt    = '0;
      ring_cmd.clear = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      alerts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      alerts_r  <= alerts_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload and the output register.
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    amt_r      <= amt_nxt;
    full_r     <= full_nxt;
    twice_r    <= twice_nxt;
    notify_r   <= notify_nxt;
    if (out_load) begin
      out_full_r   <= full_r;
      out_twice_r  <= TM_W'(twice_r);
      out_notify_r <= notify_r;
      out_alerts_r <= alerts_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_full  = out_full_r;
  assign out_twice_median = out_twice_r;
  assign out_notify       = out_notify_r;
  assign out_alert_count  = out_alerts_r;

  swma_hist #(
    .NUM_BINS   (NUM_BINS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (hist_op),
    .addr      (hist_addr),
    .low_rank  (low_rank),
    .high_rank (high_rank),
    .low_bin   (low_bin),
    .high_bin  (high_bin)
  );

  swma_ring #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win_eff),
    .cmd     (ring_cmd),
    .wr_data (amt_r),
    .rd_data (ring_old),
    .full    (ring_full)
  );

endmodule

@@ rtl/swma_checker.sv @@
// Port-level checker for the sliding window median alert block, bound to the top level.
// Depends on sliding_window_median_alert_top_assert.svh for the assertion macros.
`include "sliding_window_median_alert_top_assert.svh"

module swma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_amount,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_window_full,
  input logic [8:0]  out_twice_median,
  input logic        out_notify,
  input logic [31:0] out_alert_count
);

  // Reset leaves no result pending and starts the clearing pass.
  `SWMA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready)

  // One item at a time: after an input transfer the block is busy.
  `SWMA_ASSERT(a_busy_after_transfer, in_valid && in_ready |=> !in_ready)

  // A window write is followed by the histogram sweep, so no sample is taken.
  `SWMA_ASSERT(a_cfg_clears, psel && penable && pwrite && pready && paddr == 2'b00 |=> !in_ready)

  // A notified result carries a nonzero alert count.
  `SWMA_ASSERT(a_notify_counted, out_valid && out_notify |-> out_alert_count != 32'd0)

  // A stalled result holds its payload.
  `SWMA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_alert_count) && $stable(out_twice_median) && $stable(out_notify) && $stable(out_window_full))

endmodule

bind sliding_window_median_alert_top swma_checker u_swma_checker (.*);

@@ sim/sliding_window_median_alert_top_tb.sv @@
// Self-checking testbench for sliding_window_median_alert_top.
// Imports swma_pkg; drives samples and window_days writes, predicts every result in-line
// and compares each transfer on the result channel with the oldest expected result.
`timescale 1ns / 100ps

module sliding_window_median_alert_top_tb;
  import swma_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_TAIL  = 300;
  localparam int          DIR_ROWS    = 30;
  localparam int          PHASES      = 8;
  localparam int          HOLD_PHASE  = 5;
  localparam int          PAUSE_PHASE = 7;

  // One result as it appears on the out_ ports.
  typedef struct packed {
    logic               window_full;
    logic [TM_W-1:0]    twice_median;
    logic               notify;
    logic [ALERT_W-1:0] alert_count;
  } alert_res_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_WRITE,
    ROW_READ
  } row_kind_t;

  // A directed row: sample, register write, or register read with its expected value.
  typedef struct packed {
    row_kind_t  kind;
    logic [31:0] value;
    logic       typed;
    alert_res_t want;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] win;
    int unsigned count;
    logic        calm;
  } phase_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [AMT_W-1:0]   in_amount;
  logic               out_valid;
  logic               out_ready;
  logic               out_window_full;
  logic [TM_W-1:0]    out_twice_median;
  logic               out_notify;
  logic [ALERT_W-1:0] out_alert_count;

  // Typed expectation travelling alongside the sample that carries it.
  logic       row_typed;
  alert_res_t row_expect;

  sliding_window_median_alert_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_full  (out_window_full),
    .out_twice_median (out_twice_median),
    .out_notify       (out_notify),
    .out_alert_count  (out_alert_count)
  );

  // Predicted state of the window.
  logic [WIN_REG_W-1:0] window_reg;
  logic [10:0]          bin_tally [NUM_BINS_DEF];
  logic [AMT_W-1:0]     sample_ring [MAX_WINDOW_DEF];
  int unsigned          oldest_slot;
  int unsigned          held_count;
  logic [ALERT_W-1:0]   alert_tally;

  alert_res_t  pending_results [$];
  alert_res_t  predicted;
  int unsigned errors;
  int unsigned samples_taken;
  int unsigned full_checks;
  int unsigned notes_seen;
  int unsigned settings_used;
  int unsigned holds_done;
  bit          calm;
  bit          hold_req;

  // Directed stimulus: reset window of 5, then a window of 1, an even window of 2 and a
  // write with bits above the register width.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, 32'd0,   1'b1, '{1'b0, 9'd0,   1'b0, 32'd0}},
    '{ROW_SAMPLE, 32'd255, 1'b1, '{1'b0, 9'd0,   1'b0, 32'd0}},
    '{ROW_SAMPLE, 32'd10,  1'b1, '{1'b0, 9'd0,   1'b0, 32'd0}},
    '{ROW_SAMPLE, 32'd10,  1'b1, '{1'b0, 9'd0,   1'b0, 32'd0}},
    '{ROW_SAMPLE, 32'd10,  1'b1, '{1'b0, 9'd0,   1'b0, 32'd0}},
    '{ROW_SAMPLE, 32'd20,  1'b1, '{1'b1, 9'd20,  1'b1, 32'd1}},
    '{ROW_SAMPLE, 32'd255, 1'b1, '{1'b1, 9'd20,  1'b1, 32'd2}},
    '{ROW_SAMPLE, 32'd0,   1'b1, '{1'b1, 9'd20,  1'b0, 32'd2}},
    '{ROW_READ,   32'd5,   1'b1, '0},
    '{ROW_WRITE,  32'd0,   1'b0, '0},
    '{ROW_READ,   32'd0,   1'b1, '0},
    '{ROW_SAMPLE, 32'd0,   1'b1, '{1'b0, 9'd0,   1'b0, 32'd2}},
    '{ROW_SAMPLE, 32'd0,   1'b1, '{1'b1, 9'd0,   1'b1, 32'd3}},
    '{ROW_SAMPLE, 32'd255, 1'b1, '{1'b1, 9'd0,   1'b1, 32'd4}},
    '{ROW_SAMPLE, 32'd255, 1'b1, '{1'b1, 9'd510, 1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd128, 1'b1, '{1'b1, 9'd510, 1'b0, 32'd4}},
    '{ROW_WRITE,  32'd2,   1'b0, '0},
    '{ROW_SAMPLE, 32'd3,   1'b1, '{1'b0, 9'd0,   1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd7,   1'b1, '{1'b0, 9'd0,   1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd5,   1'b1, '{1'b1, 9'd10,  1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd10,  1'b1, '{1'b1, 9'd12,  1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd12,  1'b1, '{1'b1, 9'd15,  1'b0, 32'd4}},
    '{ROW_SAMPLE, 32'd30,  1'b1, '{1'b1, 9'd22,  1'b1, 32'd5}},
    '{ROW_SAMPLE, 32'd170, 1'b0, '0},
    '{ROW_SAMPLE, 32'd85,  1'b0, '0},
    '{ROW_WRITE,  32'hFFFF_F805, 1'b0, '0},
    '{ROW_READ,   32'd5,   1'b1, '0},
    '{ROW_SAMPLE, 32'd255, 1'b0, '0},
    '{ROW_SAMPLE, 32'd254, 1'b0, '0},
    '{ROW_SAMPLE, 32'd1,   1'b0, '0}
  };

  // Random phases: register value written, samples sent, and whether idling is off.
  phase_t phases [PHASES] = '{
    '{32'd3,    60,   1'b0},
    '{32'd4,    60,   1'b1},
    '{32'd0,    40,   1'b0},
    '{32'd2047, 60,   1'b0},
    '{32'd6,    60,   1'b0},
    '{32'd16,   90,   1'b0},
    '{32'd1,    40,   1'b1},
    '{32'd64,   100,  1'b0}
  };

  // Window length in use: zero counts as one, anything above the ring size is clipped.
  function automatic int unsigned window_len();
    int unsigned w;
    w = window_reg;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
    return w;
  endfunction

  // A register write restarts the window but keeps the alert count.
  function automatic void window_restart(logic [31:0] value);
    window_reg = value[WIN_REG_W-1:0];
    for (int i = 0; i < NUM_BINS_DEF; i++) bin_tally[i] = '0;
    oldest_slot = 0;
    held_count  = 0;
  endfunction

  // Sum of the bins holding the two middle ranks of the window.
  function automatic int unsigned hist_twice_median(int unsigned w);
    int unsigned lo_rank, hi_rank, cum, lo_bin, hi_bin;
    bit lo_found, done;
    lo_rank  = (w - 1) / 2;
    hi_rank  = w / 2;
    cum      = 0;
    lo_bin   = NUM_BINS_DEF - 1;
    hi_bin   = NUM_BINS_DEF - 1;
    lo_found = 1'b0;
    done     = 1'b0;
    for (int i = 0; i < NUM_BINS_DEF; i++) begin
      if (!done) begin
        cum += bin_tally[i];
        if (!lo_found && cum > lo_rank) begin
          lo_bin   = i;
          lo_found = 1'b1;
        end
        if (cum > hi_rank) begin
          hi_bin = i;
          done   = 1'b1;
        end
      end
    end
    return lo_bin + hi_bin;
  endfunction

  // Expected result of one sample, advancing the predicted window.
  function automatic alert_res_t predict_sample(logic [AMT_W-1:0] amt);
    alert_res_t  r;
    int unsigned w, slot, twice, old;
    r    = '0;
    w    = window_len();
    slot = oldest_slot % w;
    if (held_count >= w) begin
      old           = sample_ring[slot];
      r.window_full = 1'b1;
      twice         = hist_twice_median(w);
      r.twice_median = twice[TM_W-1:0];
      if (amt >= twice) begin
        r.notify = 1'b1;
        if (alert_tally != '1) alert_tally++;
      end
      if (bin_tally[old] > 0) bin_tally[old]--;
    end else begin
      held_count++;
    end
    bin_tally[amt]++;
    sample_ring[slot] = amt;
    slot++;
    oldest_slot   = (slot >= w) ? 0 : slot;
    r.alert_count = alert_tally;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Stop offering samples and wait until every predicted result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(logic [AMT_W-1:0] amt, logic typed, alert_res_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_amount  <= amt;
    row_typed  <= typed;
    row_expect <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register write through setup and access cycles, only with the block idle.
  task automatic cfg_write(logic [31:0] value);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_DAYS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_restart(value);
    settings_used++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(logic [31:0] want);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW_DAYS;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("window_days readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predict on every accepted sample transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted = predict_sample(in_amount);
      samples_taken++;
      if (predicted.window_full) full_checks++;
      if (row_typed) pending_results.push_back(row_expect);
      else pending_results.push_back(predicted);
    end
  end

  // Compare every accepted result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got twice_median %0d",
                 $time, out_twice_median);
      end else begin
        predicted = pending_results.pop_front();
        check_field("window_full", predicted.window_full, out_window_full);
        check_field("twice_median", predicted.twice_median, out_twice_median);
        check_field("notify", predicted.notify, out_notify);
        check_field("alert_count", predicted.alert_count, out_alert_count);
        if (out_notify === 1'b1) notes_seen++;
      end
    end
  end

  // Receiver: random stalls per result, and one long hold-off when asked.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        stall = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Main sequence: reset, directed rows, random phases, then drain.
  initial begin
    logic [AMT_W-1:0] amt;
    int unsigned      pick;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_amount     = '0;
    row_typed     = 1'b0;
    row_expect    = '0;
    errors        = 0;
    samples_taken = 0;
    full_checks   = 0;
    notes_seen    = 0;
    settings_used = 1;
    holds_done    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    alert_tally   = '0;
    window_restart({21'd0, WIN_RESET});
    for (int i = 0; i < MAX_WINDOW_DEF; i++) sample_ring[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].kind)
        ROW_SAMPLE: send_sample(dir_rows[i].value[AMT_W-1:0], dir_rows[i].typed,
                                dir_rows[i].want);
        ROW_WRITE:  cfg_write(dir_rows[i].value);
        default:    cfg_read(dir_rows[i].value);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      cfg_write(phases[p].win);
      cfg_read(phases[p].win & 32'h0000_07FF);
      calm = phases[p].calm;
      for (int k = 0; k < phases[p].count; k++) begin
        if (p == HOLD_PHASE && k == 40) hold_req = 1'b1;
        if (p == PAUSE_PHASE && k == 80) wait_results_drained();
        // Mix of extremes, small values for ties and low medians, and the full range.
        pick = $urandom_range(0, 9);
        if (pick < 2) amt = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        else if (pick < 5) amt = $urandom_range(0, 15);
        else if (pick < 7) amt = $urandom_range(0, 63);
        else amt = $urandom_range(0, 255);
        send_sample(amt, 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_results_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Covered %0d samples over %0d window settings, %0d of them against a full window.",
             samples_taken, settings_used, full_checks);
    $display("Saw %0d notifications; the receiver held off for a long stretch %0d time(s).",
             notes_seen, holds_done);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/swma_pkg.sv
rtl/swma_hist.sv
rtl/swma_ring.sv
rtl/sliding_window_median_alert_top.sv
rtl/swma_checker.sv
sim/sliding_window_median_alert_top_tb.sv
